// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL (lcdsw_back only)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/lcdsw_pkg.sv =====
`timescale 1ns / 1ps
package lcdsw_pkg;

  localparam int SHADOW_DEPTH = 64;
  localparam int SHADOW_AW    = $clog2(SHADOW_DEPTH);

  localparam logic [5:0] NIBBLE_RESET = 6'd20;
  localparam logic [7:0] WRITE_CODE   = 8'hA0;
  localparam logic [7:0] CMD_CODE     = 8'h80;

  localparam logic [2:0] WRITE_PRE = WRITE_CODE[7:5];
  localparam logic [3:0] CMD_PRE   = CMD_CODE[7:4];

  localparam int FRAME_BITS = 17;
  localparam int LEN_W      = $clog2(FRAME_BITS + 1);

  localparam logic [LEN_W-1:0] LEN_WRITE  = LEN_W'(17);
  localparam logic [LEN_W-1:0] LEN_NIBBLE = LEN_W'(13);
  localparam logic [LEN_W-1:0] LEN_CMD    = LEN_W'(12);

  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  localparam logic [1:0] KIND_MASKED = 2'd0;
  localparam logic [1:0] KIND_RAW    = 2'd1;
  localparam logic [1:0] KIND_CMD    = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       chip;
    logic [5:0] address;
    logic [7:0] data_byte;
    logic       set_bits;
  } in_item_t;

  typedef struct packed {
    logic select_one;
    logic select_two;
    logic serial_bit;
    logic last;
  } out_item_t;

  // one frame waiting for the shifter, bits MSB aligned
  typedef struct packed {
    logic                  sel_one;
    logic                  sel_two;
    logic [FRAME_BITS-1:0] bits;
    logic [LEN_W-1:0]      len;
  } frame_t;

endpackage

// ===== src/lcdsw_front.sv =====
`timescale 1ns / 1ps
module lcdsw_front
  import lcdsw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_item_t in_item,
  input  logic     cfg_we,
  input  logic [5:0] cfg_wdata,
  input  logic     q_full,
  output logic     q_push,
  output frame_t   q_frame
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_PUSH = 2'b10
  } front_state_t;

  front_state_t state_r, state_nxt;
  in_item_t     item_r;
  logic [5:0]   nibble_r;

  logic [7:0] shadow_one_r [SHADOW_DEPTH];
  logic [7:0] shadow_two_r [SHADOW_DEPTH];
  logic [SHADOW_DEPTH-1:0] valid_one_r;
  logic [SHADOW_DEPTH-1:0] valid_two_r;
  logic [7:0] rd_one_r, rd_two_r;
  logic       hit_one_r, hit_two_r, inside_r;

  logic                 accept;
  logic                 in_inside;
  logic [SHADOW_AW-1:0] rd_idx, wr_idx;
  logic [7:0]           cur, new_byte;
  logic                 nib, wr_one, wr_two;

  assign busy      = (state_r != F_IDLE);
  assign accept    = start && (state_r == F_IDLE);
  assign in_inside = ({1'b0, in_item.address} < 7'(SHADOW_DEPTH));
  assign rd_idx    = in_item.address[SHADOW_AW-1:0];
  assign wr_idx    = item_r.address[SHADOW_AW-1:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        // unused kind is dropped on accept
        if (accept && (in_item.kind == KIND_MASKED || in_item.kind == KIND_RAW ||
                       in_item.kind == KIND_CMD)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!q_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      nibble_r <= NIBBLE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        nibble_r <= cfg_wdata;
      end
    end
  end

  // shadow read launched on the accept edge
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r    <= in_item;
      inside_r  <= in_inside;
      hit_one_r <= in_inside && valid_one_r[rd_idx];
      hit_two_r <= in_inside && valid_two_r[rd_idx];
      rd_one_r  <= shadow_one_r[rd_idx];
      rd_two_r  <= shadow_two_r[rd_idx];
    end
  end

  always_comb begin
    if (item_r.chip) begin
      cur = hit_two_r ? rd_two_r : 8'h00;
    end else begin
      cur = hit_one_r ? rd_one_r : 8'h00;
    end
    if (item_r.kind == KIND_MASKED) begin
      new_byte = item_r.set_bits ? (cur | item_r.data_byte) : (cur & ~item_r.data_byte);
    end else begin
      new_byte = item_r.data_byte;
    end
  end

  assign q_push = (state_r == F_PUSH) && !q_full;
  assign wr_one = q_push && (item_r.kind == KIND_MASKED) && inside_r && !item_r.chip;
  assign wr_two = q_push && (item_r.kind == KIND_MASKED) && inside_r && item_r.chip;

  always_ff @(posedge clk) begin
    if (wr_one) begin
      shadow_one_r[wr_idx] <= new_byte;
    end
    if (wr_two) begin
      shadow_two_r[wr_idx] <= new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_one_r <= '0;
      valid_two_r <= '0;
    end else begin
      if (wr_one) begin
        valid_one_r[wr_idx] <= 1'b1;
      end
      if (wr_two) begin
        valid_two_r[wr_idx] <= 1'b1;
      end
    end
  end

  assign nib = !item_r.chip && (item_r.address == nibble_r);

  always_comb begin
    if (item_r.kind == KIND_CMD) begin
      q_frame.sel_one = 1'b1;
      q_frame.sel_two = 1'b1;
      q_frame.bits    = {CMD_PRE, item_r.data_byte, 5'b0};
      q_frame.len     = LEN_CMD;
    end else begin
      q_frame.sel_one = !item_r.chip;
      q_frame.sel_two = item_r.chip;
      q_frame.bits    = {WRITE_PRE, item_r.address, new_byte};
      q_frame.len     = nib ? LEN_NIBBLE : LEN_WRITE;
    end
  end

endmodule

// ===== src/lcdsw_queue.sv =====
`timescale 1ns / 1ps
module lcdsw_queue
  import lcdsw_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  frame_t push_frame,
  input  logic   pop,
  output frame_t head,
  output logic   empty,
  output logic   full
);

  frame_t           slot_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QAW:0]     count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == (QAW+1)'(QDEPTH));
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ===== src/lcdsw_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lcdsw_back
  import lcdsw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  frame_t    head,
  input  logic      q_empty,
  output logic      pop,
  output logic      out_strobe,
  output out_item_t out_item
);

  logic [FRAME_BITS-1:0] shift_r, shift_nxt;
  logic [LEN_W-1:0]      rem_r, rem_nxt;
  logic                  sel_one_r, sel_two_r;
  logic                  strobe_r;
  out_item_t             item_r, item_nxt;
  logic                  active;

  assign active = (rem_r != '0);
  // next frame loads while the current one sends its last bit
  assign pop    = !q_empty && (rem_r == '0 || rem_r == LEN_W'(1));

  always_comb begin
    shift_nxt = shift_r;
    rem_nxt   = rem_r;
    if (pop) begin
      shift_nxt = head.bits;
      rem_nxt   = head.len;
    end else if (active) begin
      shift_nxt = {shift_r[FRAME_BITS-2:0], 1'b0};
      rem_nxt   = rem_r - 1'b1;
    end
    item_nxt.select_one = sel_one_r;
    item_nxt.select_two = sel_two_r;
    item_nxt.serial_bit = shift_r[FRAME_BITS-1];
    item_nxt.last       = (rem_r == LEN_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      rem_r    <= rem_nxt;
      strobe_r <= active;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    item_r  <= item_nxt;
    if (pop) begin
      sel_one_r <= head.sel_one;
      sel_two_r <= head.sel_two;
    end
  end

  assign out_strobe = strobe_r;
  assign out_item   = item_r;

  `ASSERT_ALWAYS(a_rem_range, clk, rst_n, rem_r <= LEN_W'(FRAME_BITS))
  `ASSERT_IMPLIES(a_sel_on_beat, clk, rst_n, out_strobe, out_item.select_one || out_item.select_two)
  `ASSERT_NEXT(a_last_bit_beat, clk, rst_n, rem_r == LEN_W'(1), out_strobe && out_item.last)

endmodule

// ===== src/lcd_segment_serial_writer_top.sv =====
`timescale 1ns / 1ps
// Serial write engine for a two-chip segment LCD controller. Raise start with an
// operation on in_item while busy is low: masked shadow update, raw write, or a
// command to both chips (kind 3 is dropped). Each frame comes out one bit per cycle,
// MSB first, one beat per out_strobe pulse, with last on the final bit; the
// receiver cannot stall, so every strobed beat must be taken. Write frames are
// 17 bits (13 on chip one at nibble_address), commands 12. The front accepts an
// item with a shadow read, then builds and queues the frame, waiting while the
// queue is full; a two-frame queue feeds the bit shifter, which sets the sustained
// item rate. busy is high in the cycle after each accept of kinds 0 to 2 and stays
// high while the queue is full. With the shifter idle, a frame's first bit goes via
// the accept registers, a queue slot, the shift register and the output register.
// Shadow bytes are cleared at reset by per-entry valid flags, so no clearing pass
// is needed. Write cfg_wdata (nibble_address) only while the block is idle.
module lcd_segment_serial_writer_top
  import lcdsw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  input  logic       cfg_we,
  input  logic [5:0] cfg_wdata,
  output logic       out_strobe,
  output out_item_t  out_item
);

  logic   q_push, q_pop, q_empty, q_full;
  frame_t q_frame, q_head;

  lcdsw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_frame   (q_frame)
  );

  lcdsw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_frame (q_frame),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  lcdsw_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_empty    (q_empty),
    .pop        (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import lcdsw_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS = 77;

  // Predicts the serial frames of the writer and holds the beats still owed.
  class lcd_frame_scoreboard;
    logic [7:0] shadow_one [SHADOW_DEPTH];
    logic [7:0] shadow_two [SHADOW_DEPTH];
    logic [5:0] nibble_addr;
    out_item_t  owed_beats[$];
    int         errors;

    function new();
      foreach (shadow_one[i]) begin
        shadow_one[i] = 8'h00;
        shadow_two[i] = 8'h00;
      end
      nibble_addr = NIBBLE_RESET;
      errors = 0;
    endfunction

    function void note_item(in_item_t it);
      logic [7:0]  cur_val;
      logic [7:0]  new_val;
      logic [16:0] frame_bits;
      int          frame_len;
      logic        sel1;
      logic        sel2;
      out_item_t   beat;
      if (it.kind == KIND_UNUSED) return;
      if (it.kind == KIND_CMD) begin
        frame_bits = {CMD_PRE, it.data_byte, 5'b0};
        frame_len = 12;
        sel1 = 1'b1;
        sel2 = 1'b1;
      end else begin
        new_val = it.data_byte;
        if (it.kind == KIND_MASKED) begin
          cur_val = it.chip ? shadow_two[it.address] : shadow_one[it.address];
          new_val = it.set_bits ? (cur_val | it.data_byte) : (cur_val & ~it.data_byte);
          if (it.chip) shadow_two[it.address] = new_val;
          else shadow_one[it.address] = new_val;
        end
        sel1 = ~it.chip;
        sel2 = it.chip;
        // chip one at the nibble address only gets the high half
        if (!it.chip && it.address == nibble_addr) begin
          frame_bits = {WRITE_PRE, it.address, new_val[7:4], 4'b0};
          frame_len = 13;
        end else begin
          frame_bits = {WRITE_PRE, it.address, new_val};
          frame_len = 17;
        end
      end
      for (int i = 0; i < frame_len; i++) begin
        beat.select_one = sel1;
        beat.select_two = sel2;
        beat.serial_bit = frame_bits[16 - i];
        beat.last = (i == frame_len - 1);
        owed_beats.push_back(beat);
      end
    endfunction

    function void check_beat(out_item_t got);
      out_item_t want;
      if (owed_beats.size() == 0) begin
        $error("beat with nothing expected: %b", got);
        errors++;
        return;
      end
      want = owed_beats.pop_front();
      if (got.select_one !== want.select_one) begin
        $error("select_one: expected %0b, got %0b", want.select_one, got.select_one);
        errors++;
      end
      if (got.select_two !== want.select_two) begin
        $error("select_two: expected %0b, got %0b", want.select_two, got.select_two);
        errors++;
      end
      if (got.serial_bit !== want.serial_bit) begin
        $error("serial_bit: expected %0b, got %0b", want.serial_bit, got.serial_bit);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return owed_beats.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   in_item = '0;
  logic       cfg_we = 1'b0;
  logic [5:0] cfg_wdata = 6'd0;
  logic       out_strobe;
  out_item_t  out_item;
  int         cycle_count = 0;

  lcd_frame_scoreboard frame_sb = new();

  lcd_segment_serial_writer_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) frame_sb.check_beat(out_item);
  end

  function automatic in_item_t make_item(logic [1:0] kind, logic chip, logic [5:0] addr,
                                         logic [7:0] data, logic setb);
    in_item_t it;
    it.kind = kind;
    it.chip = chip;
    it.address = addr;
    it.data_byte = data;
    it.set_bits = setb;
    return it;
  endfunction

  // Mostly writes, with addresses bunched so shadow bytes build up over time.
  function automatic in_item_t random_item(logic [5:0] nib);
    in_item_t it;
    int       pick;
    it = in_item_t'($bits(in_item_t)'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 40) it.kind = KIND_MASKED;
    else if (pick < 65) it.kind = KIND_RAW;
    else if (pick < 90) it.kind = KIND_CMD;
    else it.kind = KIND_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 30) it.address = nib;
    else if (pick < 70) it.address = 6'($urandom_range(0, 7));
    else it.address = 6'($urandom_range(0, 63));
    it.data_byte = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Holds start with the item until the block takes it; returns in the accept step.
  task automatic send_item(in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    frame_sb.note_item(it);
  endtask

  task automatic wait_idle();
    while (frame_sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_nibble(logic [5:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_sb.nibble_addr = value;
  endtask

  initial begin
    in_item_t   directed[$];
    logic [5:0] phase_nib;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_item(KIND_MASKED, 1'b0, 6'd0, 8'hFF, 1'b1));
    directed.push_back(make_item(KIND_MASKED, 1'b0, 6'd0, 8'h0F, 1'b0));
    directed.push_back(make_item(KIND_MASKED, 1'b1, 6'd0, 8'hAA, 1'b1));
    directed.push_back(make_item(KIND_MASKED, 1'b1, 6'd63, 8'hFF, 1'b1));
    directed.push_back(make_item(KIND_MASKED, 1'b0, 6'd63, 8'h81, 1'b1));
    directed.push_back(make_item(KIND_MASKED, 1'b1, 6'd63, 8'h55, 1'b0));
    directed.push_back(make_item(KIND_MASKED, 1'b0, NIBBLE_RESET, 8'h3C, 1'b1));
    directed.push_back(make_item(KIND_MASKED, 1'b0, NIBBLE_RESET, 8'hFF, 1'b1));
    directed.push_back(make_item(KIND_MASKED, 1'b1, NIBBLE_RESET, 8'hC3, 1'b1));
    directed.push_back(make_item(KIND_RAW, 1'b0, NIBBLE_RESET, 8'hA5, 1'b1));
    directed.push_back(make_item(KIND_RAW, 1'b1, 6'd63, 8'h00, 1'b0));
    // raw write must leave the shadow alone; the masked update after it shows that
    directed.push_back(make_item(KIND_RAW, 1'b0, 6'd0, 8'hFF, 1'b0));
    directed.push_back(make_item(KIND_MASKED, 1'b0, 6'd0, 8'h00, 1'b1));
    directed.push_back(make_item(KIND_CMD, 1'b0, 6'd0, 8'h00, 1'b0));
    directed.push_back(make_item(KIND_CMD, 1'b1, 6'd63, 8'hFF, 1'b1));
    directed.push_back(make_item(KIND_CMD, 1'b0, 6'd21, 8'h5A, 1'b1));
    directed.push_back(make_item(KIND_UNUSED, 1'b1, 6'd63, 8'hFF, 1'b1));
    directed.push_back(make_item(KIND_UNUSED, 1'b0, 6'd0, 8'h00, 1'b0));
    directed.push_back(make_item(KIND_MASKED, 1'b0, 6'd21, 8'hFF, 1'b1));
    directed.push_back(make_item(KIND_RAW, 1'b1, 6'd0, 8'h80, 1'b0));
    foreach (directed[i]) send_item(directed[i]);
    start <= 1'b0;

    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: phase_nib = 6'd63;
        1: phase_nib = 6'd0;
        4: phase_nib = NIBBLE_RESET;
        default: phase_nib = 6'($urandom_range(0, 63));
      endcase
      write_nibble(phase_nib);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(random_item(phase_nib));
        // phase 2 runs back to back throughout
        if (phase != 2 && $urandom_range(0, 99) < 15) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      start <= 1'b0;
    end

    wait_idle();
    if (frame_sb.errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
